// ===== sv/signed_decimal_field_formatter_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the signed decimal field formatter
// Shorthands for clocked implications; expect clk and rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef SIGNED_DECIMAL_FIELD_FORMATTER_MACROS_SVH
`define SIGNED_DECIMAL_FIELD_FORMATTER_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define SDF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define SDF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/sdf_pkg.sv =====
// ----------------------------------------------------------------------------
// sdf_pkg
// Types, codes and constants shared by the signed decimal field formatter.
// ----------------------------------------------------------------------------
package sdf_pkg;

  localparam int MAX_FIELD  = 64;
  localparam int DIGITS     = 10;
  localparam int POS_W      = 7;   // holds 0..MAX_FIELD
  localparam int CNT_W      = 4;   // holds 0..DIGITS
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 7;
  localparam int VAL_W      = 32;

  // Reciprocal of ten: floor(x / 10) == (x * RECIP) >> RECIP_SHIFT for 32-bit x
  localparam logic [31:0] RECIP       = 32'hCCCC_CCCD;
  localparam int          RECIP_SHIFT = 35;

  localparam logic [6:0] CH_ZERO  = 7'h30;
  localparam logic [6:0] CH_MINUS = 7'h2D;
  localparam logic [6:0] CH_PLUS  = 7'h2B;
  localparam logic [6:0] CH_SPACE = 7'h20;
  localparam logic [6:0] CH_NONE  = 7'h00;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FIELD_WIDTH     = 3'd0,
    CFG_PRECISION       = 3'd1,
    CFG_PRECISION_GIVEN = 3'd2,
    CFG_ZERO_PAD        = 3'd3,
    CFG_LEFT_ALIGN      = 3'd4,
    CFG_PLUS_SIGN       = 3'd5,
    CFG_SPACE_SIGN      = 3'd6
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIG,
    ST_PLAN,
    ST_BOUND,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic [6:0] field_width;
    logic [5:0] precision;
    logic       precision_given;
    logic       zero_pad;
    logic       left_align;
    logic       plus_sign;
    logic       space_sign;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic mul;
    logic adv;
  } div_ctl_t;

  typedef struct packed {
    logic plan;
    logic bound;
  } lay_ctl_t;

  // Segment boundaries of the text, as character positions
  typedef struct packed {
    logic [POS_W-1:0] b_sign;
    logic [POS_W-1:0] b_zero;
    logic [POS_W-1:0] b_dig;
    logic [POS_W-1:0] b_end;
    logic [POS_W-1:0] total;
  } lay_t;

endpackage

// ===== sv/sdf_div10.sv =====
// ----------------------------------------------------------------------------
// sdf_div10
// Shared divide-by-ten unit: one registered reciprocal multiply per digit.
// ----------------------------------------------------------------------------
module sdf_div10 import sdf_pkg::*; (
  input  logic             clk,
  input  div_ctl_t         ctl,
  input  logic [VAL_W-1:0] load_val,
  output logic [3:0]       rem,
  output logic             quot_zero
);

  logic [VAL_W-1:0]   op_r, op_nxt;
  logic [2*VAL_W-1:0] prod_r;
  logic [VAL_W-1:0]   quot;
  logic [VAL_W-1:0]   quot_x10;

  assign quot      = VAL_W'(prod_r[2*VAL_W-1:RECIP_SHIFT]);
  assign quot_x10  = (quot << 3) + (quot << 1);
  assign rem       = 4'(op_r - quot_x10);
  assign quot_zero = (quot == '0);

  always_comb begin
    op_nxt = op_r;
    if (ctl.load) begin
      op_nxt = load_val;
    end else if (ctl.adv) begin
      op_nxt = quot;
    end
  end

  always_ff @(posedge clk) begin
    op_r <= op_nxt;
    if (ctl.mul) begin
      prod_r <= (2*VAL_W)'(op_r) * (2*VAL_W)'(RECIP);
    end
  end

endmodule

// ===== sv/sdf_layout.sv =====
// ----------------------------------------------------------------------------
// sdf_layout
// Two-step planner: field lengths, then segment boundaries of the text.
// ----------------------------------------------------------------------------
module sdf_layout import sdf_pkg::*; (
  input  logic             clk,
  input  lay_ctl_t         ctl,
  input  cfg_t             cfg,
  input  logic             sign_len,
  input  logic [CNT_W-1:0] digit_count,
  output lay_t             lay
);

  logic [POS_W-1:0] width, prec, zeros, body, pad, cnt_x, sign_x;
  logic [POS_W-1:0] zeros_r, pad_r, total_r;
  lay_t             lay_r, lay_nxt;

  assign cnt_x  = POS_W'(digit_count);
  assign sign_x = POS_W'(sign_len);

  always_comb begin
    width = (cfg.field_width > POS_W'(MAX_FIELD)) ? POS_W'(MAX_FIELD) : cfg.field_width;
    if (!cfg.precision_given && cfg.zero_pad && !cfg.left_align) begin
      prec = (width > sign_x) ? width - sign_x : '0;
    end else if (!cfg.precision_given) begin
      prec = '0;
    end else begin
      prec = POS_W'(cfg.precision);
    end
    if (prec > POS_W'(MAX_FIELD - 1)) begin
      prec = POS_W'(MAX_FIELD - 1);
    end
    zeros = (prec > cnt_x) ? prec - cnt_x : '0;
    body  = sign_x + zeros + cnt_x;
    pad   = (width > body) ? width - body : '0;
  end

  always_comb begin
    lay_nxt.b_sign = cfg.left_align ? '0 : pad_r;
    lay_nxt.b_zero = lay_nxt.b_sign + sign_x;
    lay_nxt.b_dig  = lay_nxt.b_zero + zeros_r;
    lay_nxt.b_end  = lay_nxt.b_dig + cnt_x;
    lay_nxt.total  = total_r;
  end

  always_ff @(posedge clk) begin
    if (ctl.plan) begin
      zeros_r <= zeros;
      pad_r   <= pad;
      total_r <= body + pad;
    end
    if (ctl.bound) begin
      lay_r <= lay_nxt;
    end
  end

  assign lay = lay_r;

endmodule

// ===== sv/signed_decimal_field_formatter.sv =====
// ----------------------------------------------------------------------------
// signed_decimal_field_formatter
// Formats a signed 32-bit value as printf %d text, one character a transaction.
// ----------------------------------------------------------------------------
//   channel | direction | handshake          | payload
//   in      | sink      | in_valid/in_stall  | in_value (32, signed)
//   out     | source    | out_valid/out_stall| out_char_code, out_has_char, out_last
//   cfg     | sink      | cfg_we             | cfg_index (3), cfg_data (7)
//
// Steps: accept, then a multiply and a digit step per converted digit (up to
// 10 digits, none for zero) in the shared divide-by-ten multiplier, a plan
// and a bound step for layout, then one character per cycle into the output
// register while out_stall does not hold the emit step.
// in_stall is high from accept until the last character enters the output
// register; the next value may be taken while that character still waits.
// Reset (rst_n low, synchronous) clears the sequencer, output valid and the
// configuration registers. out_stall holds the output register and the emit step.
// ----------------------------------------------------------------------------
module signed_decimal_field_formatter import sdf_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic signed [31:0]    in_value,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [6:0]            out_char_code,
  output logic                  out_has_char,
  output logic                  out_last,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  state_t           state_r, state_nxt;
  cfg_t             cfg_r;
  div_ctl_t         div_ctl;
  lay_ctl_t         lay_ctl;
  lay_t             lay;

  logic [3:0]       digit_store_r [DIGITS];
  logic [CNT_W-1:0] digit_count_r;
  logic [CNT_W-1:0] dig_idx_r;
  logic [POS_W-1:0] pos_r;
  logic [6:0]       sign_ch_r;
  logic             sign_len_r;

  logic             out_valid_r;
  logic [6:0]       out_char_r;
  logic             out_has_r;
  logic             out_last_r;

  logic             in_fire;
  logic             emit_fire;
  logic             emit_last;
  logic             digit_sel;
  logic [6:0]       emit_char;
  logic [VAL_W-1:0] in_uval;
  logic [VAL_W-1:0] mag;
  logic [3:0]       rem;
  logic             quot_zero;

  assign in_fire = in_valid && !in_stall;
  assign in_uval = VAL_W'(in_value);
  // Magnitude of the most negative value wraps to 0x8000_0000, still correct
  assign mag     = in_uval[VAL_W-1] ? (VAL_W'(0) - in_uval) : in_uval;

  // Configuration writes; the user must issue them only while idle, the block does not enforce it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_FIELD_WIDTH:     cfg_r.field_width     <= cfg_data;
        CFG_PRECISION:       cfg_r.precision       <= cfg_data[5:0];
        CFG_PRECISION_GIVEN: cfg_r.precision_given <= cfg_data[0];
        CFG_ZERO_PAD:        cfg_r.zero_pad        <= cfg_data[0];
        CFG_LEFT_ALIGN:      cfg_r.left_align      <= cfg_data[0];
        CFG_PLUS_SIGN:       cfg_r.plus_sign       <= cfg_data[0];
        CFG_SPACE_SIGN:      cfg_r.space_sign      <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  sdf_div10 u_div (
    .clk       (clk),
    .ctl       (div_ctl),
    .load_val  (mag),
    .rem       (rem),
    .quot_zero (quot_zero)
  );

  sdf_layout u_layout (
    .clk         (clk),
    .ctl         (lay_ctl),
    .cfg         (cfg_r),
    .sign_len    (sign_len_r),
    .digit_count (digit_count_r),
    .lay         (lay)
  );

  // Character at the current position, picked by segment
  always_comb begin
    digit_sel = 1'b0;
    if (pos_r < lay.b_sign) begin
      emit_char = CH_SPACE;
    end else if (pos_r < lay.b_zero) begin
      emit_char = sign_ch_r;
    end else if (pos_r < lay.b_dig) begin
      emit_char = CH_ZERO;
    end else if (pos_r < lay.b_end) begin
      emit_char = CH_ZERO + 7'(digit_store_r[dig_idx_r]);
      digit_sel = 1'b1;
    end else begin
      emit_char = CH_SPACE;
    end
  end

  // Empty text counts as one result with no character
  assign emit_last = (lay.total == '0) || (pos_r + POS_W'(1) == lay.total);

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          state_nxt = (mag == '0) ? ST_PLAN : ST_MUL;
        end
      end
      ST_MUL:   state_nxt = ST_DIG;
      ST_DIG:   state_nxt = quot_zero ? ST_PLAN : ST_MUL;
      ST_PLAN:  state_nxt = ST_BOUND;
      ST_BOUND: state_nxt = ST_EMIT;
      ST_EMIT: begin
        if (emit_fire && emit_last) begin
          state_nxt = ST_IDLE;
        end
      end
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_stall  = 1'b1;
    div_ctl   = '0;
    lay_ctl   = '0;
    emit_fire = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        // in_stall is low here, so an offered value is a transaction
        in_stall     = 1'b0;
        div_ctl.load = in_valid;
      end
      ST_MUL:   div_ctl.mul   = 1'b1;
      ST_DIG:   div_ctl.adv   = 1'b1;
      ST_PLAN:  lay_ctl.plan  = 1'b1;
      ST_BOUND: lay_ctl.bound = 1'b1;
      ST_EMIT:  emit_fire     = !out_valid_r || !out_stall;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Digit collection and emit position
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      digit_count_r <= '0;
      pos_r         <= '0;
    end else begin
      if (in_fire) begin
        digit_count_r <= '0;
        // Zero without a precision still prints one digit
        if (mag == '0 && !cfg_r.precision_given) begin
          digit_store_r[0] <= '0;
          digit_count_r    <= CNT_W'(1);
        end
      end else if (state_r == ST_DIG) begin
        digit_store_r[digit_count_r] <= rem;
        digit_count_r                <= digit_count_r + CNT_W'(1);
      end
      if (state_r == ST_BOUND) begin
        pos_r <= '0;
      end else if (emit_fire) begin
        pos_r <= pos_r + POS_W'(1);
      end
    end
  end

  // Sign and most-significant-first digit pointer
  always_ff @(posedge clk) begin
    if (in_fire) begin
      if (in_uval[VAL_W-1]) begin
        sign_ch_r  <= CH_MINUS;
        sign_len_r <= 1'b1;
      end else if (cfg_r.plus_sign) begin
        sign_ch_r  <= CH_PLUS;
        sign_len_r <= 1'b1;
      end else if (cfg_r.space_sign) begin
        sign_ch_r  <= CH_SPACE;
        sign_len_r <= 1'b1;
      end else begin
        sign_ch_r  <= CH_NONE;
        sign_len_r <= 1'b0;
      end
    end
    if (state_r == ST_BOUND) begin
      dig_idx_r <= digit_count_r - CNT_W'(1);
    end else if (emit_fire && digit_sel) begin
      dig_idx_r <= dig_idx_r - CNT_W'(1);
    end
  end

  // Output register: load on emit, drop valid once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit_fire) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_fire) begin
      out_has_r  <= (lay.total != '0);
      out_char_r <= (lay.total != '0) ? emit_char : CH_NONE;
      out_last_r <= emit_last;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_char_code = out_char_r;
  assign out_has_char  = out_has_r;
  assign out_last      = out_last_r;

endmodule

// ===== sv/sdf_chk.sv =====
// ----------------------------------------------------------------------------
// sdf_chk
// Port-level checker for the signed decimal field formatter, bound to the top.
// ----------------------------------------------------------------------------
`include "signed_decimal_field_formatter_macros.svh"

module sdf_chk import sdf_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [6:0]  out_char_code,
  input logic        out_has_char,
  input logic        out_last
);

  logic [1:0] open_r;
  logic       in_take;
  logic       last_take;
  logic       prev_done;
  logic       empty_ok;
  logic       out_wait;
  logic [8:0] out_word;

  assign in_take   = in_valid && !in_stall;
  assign last_take = out_valid && !out_stall && out_last;
  // A new value may only overlap the still-waiting last result of the one before
  assign prev_done = (open_r == 2'd0) || (open_r == 2'd1 && out_valid && out_last);
  assign empty_ok  = out_last && (out_char_code == CH_NONE);
  assign out_wait  = out_valid && out_stall;
  assign out_word  = {out_char_code, out_has_char, out_last};

  // Count values taken in whose last result has not been taken out yet
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r <= 2'd0;
    end else begin
      open_r <= open_r + 2'(in_take) - 2'(last_take);
    end
  end

  `SDF_ASSERT_NOW(a_one_value_at_a_time, in_take, prev_done, "input taken while busy")
  `SDF_ASSERT_NOW(a_no_stray_result, out_valid, open_r != 2'd0, "result with no value open")
  `SDF_ASSERT_NOW(a_empty_is_last, out_valid && !out_has_char, empty_ok, "empty result not last")
  `SDF_ASSERT_NEXT(a_out_hold, out_wait, out_valid && $stable(out_word), "stalled result moved")

endmodule

bind signed_decimal_field_formatter sdf_chk u_sdf_chk (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_char_code (out_char_code),
  .out_has_char  (out_has_char),
  .out_last      (out_last)
);

// ===== tb/signed_decimal_field_formatter_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// signed_decimal_field_formatter_tb
// Self-checking bench for the %d formatter: a queue-fed driver offers signed
// values, a scoreboard predicts each character of the formatted text, and a
// monitor compares every character transaction against it. Format settings
// change between drained phases; sender and receiver idle at random.
// ----------------------------------------------------------------------------
module signed_decimal_field_formatter_tb;
  import sdf_pkg::*;

  localparam int CYCLE_LIMIT = 400_000;
  localparam int TAIL_CYCLES = 100;

  typedef struct packed {
    logic [6:0] char_code;
    logic       has_char;
    logic       last;
  } char_result_t;

  // Clock and reset
  logic clk   = 1'b0;
  logic rst_n = 1'b0;
  always #4 clk = ~clk;

  // DUT ports; the driven inputs are known from time zero
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  logic signed [31:0]    in_value  = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [6:0]            out_char_code;
  logic                  out_has_char;
  logic                  out_last;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_FIELD_WIDTH;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  // Bench state
  logic [31:0]  pending_values[$];
  char_result_t expected_chars[$];
  cfg_t         fmt = '0;          // mirror of the format registers
  int           send_idle_pct = 34;
  int           recv_idle_pct = 45;
  int           values_sent    = 0;
  int           chars_checked  = 0;
  int           formats_applied = 0;
  int           fail_count     = 0;
  int           cycle_count    = 0;

  signed_decimal_field_formatter uut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_value     (in_value),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_char_code(out_char_code),
    .out_has_char (out_has_char),
    .out_last     (out_last),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  // --------------------------------------------------------------------------
  // Build the %d text for one value under the current format and queue each
  // character as an expected transaction.
  // --------------------------------------------------------------------------
  function automatic void format_expected_text(logic [31:0] value);
    logic [31:0]  mag;
    logic [6:0]   sign_ch;
    logic [3:0]   digs[DIGITS];
    logic [6:0]   text[$];
    char_result_t r;
    int           sign_len, width, prec, ndig, zeros, body, pad, i;

    mag     = value[31] ? (32'd0 - value) : value;
    sign_ch = value[31] ? CH_MINUS : fmt.plus_sign ? CH_PLUS :
              fmt.space_sign ? CH_SPACE : CH_NONE;
    sign_len = (sign_ch != CH_NONE) ? 1 : 0;
    width    = (fmt.field_width > MAX_FIELD) ? MAX_FIELD : int'(fmt.field_width);

    // Zero flag turns the width into a precision, unless left aligned or a precision is given
    if (!fmt.precision_given && fmt.zero_pad && !fmt.left_align)
      prec = (width > sign_len) ? width - sign_len : 0;
    else if (!fmt.precision_given)
      prec = 0;
    else
      prec = int'(fmt.precision);
    if (prec > MAX_FIELD - 1)
      prec = MAX_FIELD - 1;

    // Zero with an explicit precision has no digits of its own
    ndig = 0;
    if (mag == 0 && !fmt.precision_given) begin
      digs[0] = 4'd0;
      ndig    = 1;
    end
    while (mag != 0) begin
      digs[ndig] = 4'(mag % 10);
      mag        = mag / 10;
      ndig++;
    end

    zeros = (prec > ndig) ? prec - ndig : 0;
    body  = sign_len + zeros + ndig;
    pad   = (width > body) ? width - body : 0;

    if (!fmt.left_align)
      for (i = 0; i < pad; i++) text.push_back(CH_SPACE);
    if (sign_len != 0)
      text.push_back(sign_ch);
    for (i = 0; i < zeros; i++) text.push_back(CH_ZERO);
    for (i = ndig - 1; i >= 0; i--) text.push_back(CH_ZERO + 7'(digs[i]));
    if (fmt.left_align)
      for (i = 0; i < pad; i++) text.push_back(CH_SPACE);

    // Empty text still yields one transaction, flagged as carrying no character
    if (text.size() == 0) begin
      r = '{char_code: CH_NONE, has_char: 1'b0, last: 1'b1};
      expected_chars.push_back(r);
    end else begin
      for (i = 0; i < text.size(); i++) begin
        r = '{char_code: text[i], has_char: 1'b1, last: (i == text.size() - 1)};
        expected_chars.push_back(r);
      end
    end
  endfunction

  function automatic logic [31:0] random_value();
    logic [31:0] v;
    case ($urandom_range(7))
      0, 1: v = $urandom;
      2, 3: v = $urandom_range(400) - 200;
      4: begin
        case ($urandom_range(4))
          0:       v = 32'h0000_0000;
          1:       v = 32'h0000_0001;
          2:       v = 32'hFFFF_FFFF;
          3:       v = 32'h7FFF_FFFF;
          default: v = 32'h8000_0000;
        endcase
      end
      default: v = $signed($urandom) >>> $urandom_range(31);
    endcase
    return v;
  endfunction

  // Mostly narrow fields; now and then the full register range
  function automatic cfg_t random_format();
    cfg_t f;
    f.field_width     = ($urandom_range(7) == 0) ? 7'($urandom_range(127))
                                                 : 7'($urandom_range(16));
    f.precision       = ($urandom_range(7) == 0) ? 6'($urandom_range(63))
                                                 : 6'($urandom_range(12));
    f.precision_given = 1'($urandom_range(1));
    f.zero_pad        = 1'($urandom_range(1));
    f.left_align      = 1'($urandom_range(1));
    f.plus_sign       = 1'($urandom_range(1));
    f.space_sign      = 1'($urandom_range(1));
    return f;
  endfunction

  // Hold until no value waits to be sent and every character has come back.
  // Sample on the falling edge so the clocked blocks have settled.
  task automatic wait_drained();
    @(negedge clk);
    while (pending_values.size() != 0 || in_valid || expected_chars.size() != 0)
      @(negedge clk);
  endtask

  // Write all seven format registers back to back, then mirror them.
  task automatic program_format(cfg_t f);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_FIELD_WIDTH;
    cfg_data  <= f.field_width;
    @(posedge clk);
    cfg_index <= CFG_PRECISION;
    cfg_data  <= {1'b0, f.precision};
    @(posedge clk);
    cfg_index <= CFG_PRECISION_GIVEN;
    cfg_data  <= {6'd0, f.precision_given};
    @(posedge clk);
    cfg_index <= CFG_ZERO_PAD;
    cfg_data  <= {6'd0, f.zero_pad};
    @(posedge clk);
    cfg_index <= CFG_LEFT_ALIGN;
    cfg_data  <= {6'd0, f.left_align};
    @(posedge clk);
    cfg_index <= CFG_PLUS_SIGN;
    cfg_data  <= {6'd0, f.plus_sign};
    @(posedge clk);
    cfg_index <= CFG_SPACE_SIGN;
    cfg_data  <= {6'd0, f.space_sign};
    @(posedge clk);
    cfg_we <= 1'b0;
    fmt = f;
    formats_applied++;
    @(negedge clk);
  endtask

  // Registers change only while the formatter is idle
  task automatic start_phase(cfg_t f);
    wait_drained();
    program_format(f);
  endtask

  // --------------------------------------------------------------------------
  // Driver: record each accepted transaction with the scoreboard, then offer
  // the next pending value unless this cycle idles. Hold the payload while
  // stalled.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        format_expected_text(in_value);
        values_sent++;
      end
      if (!in_valid || !in_stall) begin
        if (pending_values.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_value <= pending_values.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: compare each accepted character against the oldest expectation,
  // then decide the stall for the next cycle.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    char_result_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_chars.size() == 0) begin
          $error("unexpected character transaction: char_code %02h has_char %0b last %0b",
                 out_char_code, out_has_char, out_last);
          fail_count++;
        end else begin
          want = expected_chars.pop_front();
          if (out_char_code !== want.char_code) begin
            $error("char_code: expected %02h, got %02h", want.char_code, out_char_code);
            fail_count++;
          end
          if (out_has_char !== want.has_char) begin
            $error("has_char: expected %0b, got %0b", want.has_char, out_has_char);
            fail_count++;
          end
          if (out_last !== want.last) begin
            $error("last: expected %0b, got %0b", want.last, out_last);
            fail_count++;
          end
          chars_checked++;
        end
      end
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Watchdog: a hung handshake ends the run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    cfg_t f;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Plain %d, including both ends of the range
    f = '0;
    start_phase(f);
    pending_values.push_back(32'd0);
    pending_values.push_back(32'd1);
    pending_values.push_back(32'hFFFF_FFFF);
    pending_values.push_back(32'h7FFF_FFFF);
    pending_values.push_back(32'h8000_0000);
    pending_values.push_back(32'd10);
    pending_values.push_back(-32'sd1000000000);

    // Zero flag fills the width, one place less when a sign shows
    f = '0;
    f.field_width = 7'd12;
    f.zero_pad    = 1'b1;
    f.plus_sign   = 1'b1;
    start_phase(f);
    pending_values.push_back(32'd42);
    pending_values.push_back(-32'sd42);
    pending_values.push_back(32'd0);

    f.plus_sign  = 1'b0;
    f.space_sign = 1'b1;
    start_phase(f);
    pending_values.push_back(32'd0);
    pending_values.push_back(32'd99);

    // Zero flag is dropped when left aligned
    f = '0;
    f.field_width = 7'd10;
    f.zero_pad    = 1'b1;
    f.left_align  = 1'b1;
    f.plus_sign   = 1'b1;
    start_phase(f);
    pending_values.push_back(32'd7);
    pending_values.push_back(-32'sd7);

    // Explicit precision of zero: zero formats to empty text
    f = '0;
    f.precision_given = 1'b1;
    start_phase(f);
    pending_values.push_back(32'd0);
    pending_values.push_back(32'd5);

    // ... or to spaces only when a width is set
    f.field_width = 7'd5;
    start_phase(f);
    pending_values.push_back(32'd0);

    f.field_width = 7'd3;
    f.precision   = 6'd8;
    start_phase(f);
    pending_values.push_back(-32'sd123);
    pending_values.push_back(32'd0);

    // Oversize width and precision clamp to a full-length field
    f = '1;
    start_phase(f);
    pending_values.push_back(32'h8000_0000);
    pending_values.push_back(32'd0);

    f = '0;
    f.field_width = 7'd64;
    f.zero_pad    = 1'b1;
    start_phase(f);
    pending_values.push_back(32'hFFFF_FFFF);

    // Random phases: receiver-heavy idling, sender-heavy idling, then none
    for (int mode = 0; mode < 3; mode++) begin
      wait_drained();
      send_idle_pct = (mode == 0) ? 34 : (mode == 1) ? 45 : 0;
      recv_idle_pct = (mode == 0) ? 45 : (mode == 1) ? 34 : 0;
      for (int p = 0; p < 6; p++) begin
        start_phase(random_format());
        for (int n = 0; n < 22; n++) begin
          // Let the pipeline run dry once per idling mode
          if (p == 0 && n == 11)
            wait_drained();
          pending_values.push_back(random_value());
        end
      end
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (expected_chars.size() != 0) begin
      $error("%0d expected characters never arrived", expected_chars.size());
      fail_count++;
    end

    $display("Formatted %0d values under %0d register settings; %0d characters checked.",
             values_sent, formats_applied, chars_checked);
    $display("Idling covered sender-heavy, receiver-heavy and back-to-back traffic.");
    if (fail_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
